[rtl/fwps_pkg.sv]
// Package with the shared constants and types of the frame window progress scoreboard.
package fwps_pkg;

    localparam int FRAME_WINDOW = 8;
    localparam int MAX_SYMBOLS  = 32;
    localparam int NUM_KINDS    = 12;

    localparam int SLOT_W  = (FRAME_WINDOW > 1) ? $clog2(FRAME_WINDOW) : 1;
    localparam int SYM_W   = 5;
    localparam int KIND_W  = 4;
    localparam int SYMA_W  = (MAX_SYMBOLS >= 32) ? SYM_W :
                             ((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1);
    localparam int ROW_W   = SYMA_W + KIND_W;
    localparam int PADDR_W = SLOT_W + ROW_W;
    localparam int PDEPTH  = FRAME_WINDOW * (2 ** ROW_W);
    localparam int CNT_W   = 16;
    localparam int TWORD_W = CNT_W + 1;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TASK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TIME  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PILOT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ZF    = 4'd3;

    localparam logic [2:0] REG_TIME_SAMPLES = 3'd0;
    localparam logic [2:0] REG_TASKS        = 3'd1;
    localparam logic [2:0] REG_USERS        = 3'd2;
    localparam logic [2:0] REG_ZF_START     = 3'd3;
    localparam logic [2:0] REG_ZF_END       = 3'd4;

    typedef struct packed {
        logic [15:0] time_samples_per_symbol;
        logic [15:0] tasks_per_frame;
        logic [11:0] users_count;
        logic [11:0] zf_range_start;
        logic [11:0] zf_range_end;
    } cfg_t;

endpackage

[rtl/frame_window_progress_scoreboard.sv]
// Top level of the frame window progress scoreboard: configuration registers and memories.
//
// Usage: a word is accepted at a rising edge with start high and busy low. Its
// result appears in the next cycle (frame outside the window) or after the execute
// state (in the window) on the result ports, marked by result_valid for exactly one
// cycle; the receiver cannot stall, so every result is taken when shown.
// For an in-window word the progress counter memory and the task memory are each
// read in the accept cycle and written back, where changed, in the next, and the
// block does not take a new word until the write-back is done. A word outside the
// window is answered from registers, so such words may be taken every cycle.
// A task report that brings its frame's count to the target starts a check of the
// base frame (states RCHK, RCMP); each frame that then retires has every row of its
// slot (2^(symbol bits + kind bits), 512 here) cleared in RCLR before the next check,
// while busy stays high; the single result then shows the new window base.
// After reset busy stays high while both memories are swept to zero, PDEPTH entries
// (4096 here). Configuration writes through cfg_we, cfg_index and cfg_wdata
// take effect at once and may be made whenever no word is in flight, also during
// that sweep. Write indexes beyond the register list are ignored.
module frame_window_progress_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  kind,
    input  logic [31:0] frame_number,
    input  logic [4:0]  symbol_index,
    input  logic [11:0] amount,
    input  logic [11:0] sc_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output logic        result_valid,
    output logic        in_window,
    output logic [15:0] count,
    output logic        encode_ready,
    output logic        frame_done,
    output logic [31:0] window_base
);

    fwps_pkg::cfg_t cfg_reg;

    // Configuration registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fwps_pkg::REG_TIME_SAMPLES: cfg_reg.time_samples_per_symbol <= cfg_wdata;
                fwps_pkg::REG_TASKS:        cfg_reg.tasks_per_frame <= cfg_wdata;
                fwps_pkg::REG_USERS:        cfg_reg.users_count <= cfg_wdata[11:0];
                fwps_pkg::REG_ZF_START:     cfg_reg.zf_range_start <= cfg_wdata[11:0];
                fwps_pkg::REG_ZF_END:       cfg_reg.zf_range_end <= cfg_wdata[11:0];
                default:
                begin
                end
            endcase
        end
    end

    logic                              p_we;
    logic [fwps_pkg::PADDR_W-1:0]      p_waddr;
    logic [fwps_pkg::CNT_W-1:0]        p_wdata;
    logic [fwps_pkg::PADDR_W-1:0]      p_raddr;
    logic [fwps_pkg::CNT_W-1:0]        p_rdata;
    logic                              t_we;
    logic [fwps_pkg::SLOT_W-1:0]       t_waddr;
    logic [fwps_pkg::TWORD_W-1:0]      t_wdata;
    logic [fwps_pkg::SLOT_W-1:0]       t_raddr;
    logic [fwps_pkg::TWORD_W-1:0]      t_rdata;

    // Progress counters, addressed by slot, symbol and kind.
    fwps_ram #(
        .WIDTH (fwps_pkg::CNT_W),
        .DEPTH (fwps_pkg::PDEPTH)
    ) u_progress_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Task count and encode-ready flag of each slot, in one word.
    fwps_ram #(
        .WIDTH (fwps_pkg::TWORD_W),
        .DEPTH (fwps_pkg::FRAME_WINDOW)
    ) u_task_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    fwps_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .kind         (kind),
        .frame_number (frame_number),
        .symbol_index (symbol_index),
        .amount       (amount),
        .sc_index     (sc_index),
        .result_valid (result_valid),
        .in_window    (in_window),
        .count        (count),
        .encode_ready (encode_ready),
        .frame_done   (frame_done),
        .window_base  (window_base),
        .p_we         (p_we),
        .p_waddr      (p_waddr),
        .p_wdata      (p_wdata),
        .p_raddr      (p_raddr),
        .p_rdata      (p_rdata),
        .t_we         (t_we),
        .t_waddr      (t_waddr),
        .t_wdata      (t_wdata),
        .t_raddr      (t_raddr),
        .t_rdata      (t_rdata)
    );

endmodule

[rtl/fwps_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module fwps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/fwps_engine.sv]
// Sequencer and datapath that read, modify and write back the scoreboard memories.
module fwps_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fwps_pkg::cfg_t                   cfg,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       op,
    input  logic [3:0]                       kind,
    input  logic [31:0]                      frame_number,
    input  logic [4:0]                       symbol_index,
    input  logic [11:0]                      amount,
    input  logic [11:0]                      sc_index,
    output logic                             result_valid,
    output logic                             in_window,
    output logic [15:0]                      count,
    output logic                             encode_ready,
    output logic                             frame_done,
    output logic [31:0]                      window_base,
    output logic                             p_we,
    output logic [fwps_pkg::PADDR_W-1:0]     p_waddr,
    output logic [fwps_pkg::CNT_W-1:0]       p_wdata,
    output logic [fwps_pkg::PADDR_W-1:0]     p_raddr,
    input  logic [fwps_pkg::CNT_W-1:0]       p_rdata,
    output logic                             t_we,
    output logic [fwps_pkg::SLOT_W-1:0]      t_waddr,
    output logic [fwps_pkg::TWORD_W-1:0]     t_wdata,
    output logic [fwps_pkg::SLOT_W-1:0]      t_raddr,
    input  logic [fwps_pkg::TWORD_W-1:0]     t_rdata
);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_RCHK = 3'd3;
    localparam logic [2:0] ST_RCMP = 3'd4;
    localparam logic [2:0] ST_RCLR = 3'd5;

    localparam int SW = fwps_pkg::SLOT_W;
    localparam int RW = fwps_pkg::ROW_W;
    localparam int PW = fwps_pkg::PADDR_W;
    localparam int NW = SW + 1;
    localparam logic [SW:0] FW_EXT = (SW + 1)'(fwps_pkg::FRAME_WINDOW);
    localparam logic [NW-1:0] FW_N = NW'(fwps_pkg::FRAME_WINDOW);
    localparam logic [SW-1:0] LAST_SLOT = SW'(fwps_pkg::FRAME_WINDOW - 1);

    logic [2:0]     state_reg, state_next;
    logic [31:0]    base_reg, base_next;
    logic [SW-1:0]  bslot_reg, bslot_next;
    logic [PW-1:0]  sweep_reg, sweep_next;
    logic [NW-1:0]  nret_reg, nret_next;
    logic           selfclr_reg, selfclr_next;

    logic [1:0]     op_reg;
    logic [3:0]     kind_reg;
    logic           sym0_reg;
    logic           valid_reg;
    logic [12:0]    inc_reg;
    logic [SW-1:0]  slot_reg;

    logic           ov_reg, ov_next;
    logic           oin_reg, oin_next;
    logic [15:0]    ocnt_reg, ocnt_next;
    logic           ordy_reg, ordy_next;
    logic           odone_reg, odone_next;
    logic [31:0]    obase_reg, obase_next;

    // Window test and slot of the incoming word.
    logic [31:0]    diff;
    logic           win_hit;
    logic [SW:0]    slot_sum;
    logic [SW-1:0]  slot_in;
    logic           per_frame;
    logic [4:0]     sym_eff;
    logic           row_ok;
    logic [12:0]    zf_lo, zf_hi, inc_in;
    logic           accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign diff      = frame_number - base_reg;
    assign win_hit   = (frame_number >= base_reg) && (diff < 32'(fwps_pkg::FRAME_WINDOW));
    assign slot_sum  = {1'b0, bslot_reg} + {1'b0, diff[SW-1:0]};
    assign slot_in   = (slot_sum >= FW_EXT) ? SW'(slot_sum - FW_EXT) : slot_sum[SW-1:0];
    assign per_frame = (kind == fwps_pkg::KIND_PILOT) || (kind == fwps_pkg::KIND_ZF);
    assign sym_eff   = per_frame ? 5'd0 : symbol_index;
    assign row_ok    = (kind < 4'(fwps_pkg::NUM_KINDS)) &&
                       (6'(sym_eff) < 6'(fwps_pkg::MAX_SYMBOLS));

    // Zero-forcing overlap of [sc, sc + users) with the configured range.
    always_comb
    begin
        zf_lo = (sc_index > cfg.zf_range_start) ? {1'b0, sc_index} : {1'b0, cfg.zf_range_start};
        zf_hi = {1'b0, sc_index} + {1'b0, cfg.users_count};
        if (zf_hi > {1'b0, cfg.zf_range_end})
        begin
            zf_hi = {1'b0, cfg.zf_range_end};
        end
        if (kind == fwps_pkg::KIND_ZF)
        begin
            inc_in = (zf_hi > zf_lo) ? (zf_hi - zf_lo) : 13'd0;
        end
        else
        begin
            inc_in = {1'b0, amount};
        end
    end

    // Execute-stage arithmetic.
    logic [16:0] psum;
    logic [15:0] pnew;
    logic [16:0] tsum;
    logic [15:0] tnew;
    logic        set_rdy;

    assign psum    = {1'b0, p_rdata} + {4'b0, inc_reg};
    assign pnew    = psum[16] ? 16'hFFFF : psum[15:0];
    assign tsum    = {1'b0, t_rdata[15:0]} + 17'd1;
    assign tnew    = tsum[16] ? 16'hFFFF : tsum[15:0];
    assign set_rdy = valid_reg && (op_reg == fwps_pkg::OP_ADD) &&
                     (kind_reg == fwps_pkg::KIND_TIME) && sym0_reg &&
                     (pnew == cfg.time_samples_per_symbol);

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        bslot_next   = bslot_reg;
        sweep_next   = sweep_reg;
        nret_next    = nret_reg;
        selfclr_next = selfclr_reg;
        ov_next      = 1'b0;
        oin_next     = oin_reg;
        ocnt_next    = ocnt_reg;
        ordy_next    = ordy_reg;
        odone_next   = odone_reg;
        obase_next   = obase_reg;
        p_we         = 1'b0;
        p_waddr      = sweep_reg;
        p_wdata      = '0;
        p_raddr      = {slot_in, sym_eff[fwps_pkg::SYMA_W-1:0], kind};
        t_we         = 1'b0;
        t_waddr      = slot_reg;
        t_wdata      = '0;
        t_raddr      = slot_in;

        case (state_reg)
            ST_INIT:
            begin
                // Clear both memories after reset, one progress entry a cycle.
                p_we = 1'b1;
                if ((sweep_reg[RW-1:0] == '0) && (sweep_reg[PW-1 -: SW] <= LAST_SLOT))
                begin
                    t_we    = 1'b1;
                    t_waddr = sweep_reg[PW-1 -: SW];
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == PW'(fwps_pkg::PDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (win_hit)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        oin_next   = 1'b0;
                        ocnt_next  = '0;
                        ordy_next  = 1'b0;
                        odone_next = 1'b0;
                        obase_next = base_reg;
                    end
                end
            end
            ST_EXEC:
            begin
                oin_next   = 1'b1;
                obase_next = base_reg;
                if (op_reg == fwps_pkg::OP_TASK)
                begin
                    t_we       = 1'b1;
                    t_wdata    = {t_rdata[16], tnew};
                    ocnt_next  = tnew;
                    ordy_next  = t_rdata[16];
                    odone_next = (tnew == cfg.tasks_per_frame);
                    if (tnew == cfg.tasks_per_frame)
                    begin
                        nret_next    = '0;
                        selfclr_next = 1'b0;
                        state_next   = ST_RCHK;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (valid_reg && (op_reg == fwps_pkg::OP_ADD))
                    begin
                        p_we    = 1'b1;
                        p_waddr = {slot_reg, sweep_reg[RW-1:0]};
                        p_wdata = pnew;
                    end
                    if (set_rdy)
                    begin
                        t_we    = 1'b1;
                        t_wdata = {1'b1, t_rdata[15:0]};
                    end
                    if (!valid_reg)
                    begin
                        ocnt_next = '0;
                    end
                    else if (op_reg == fwps_pkg::OP_ADD)
                    begin
                        ocnt_next = pnew;
                    end
                    else
                    begin
                        ocnt_next = p_rdata;
                    end
                    ordy_next  = t_rdata[16] || set_rdy;
                    odone_next = (t_rdata[15:0] == cfg.tasks_per_frame);
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RCHK:
            begin
                t_raddr    = bslot_reg;
                state_next = ST_RCMP;
            end
            ST_RCMP:
            begin
                if ((t_rdata[15:0] == cfg.tasks_per_frame) && (nret_reg < FW_N))
                begin
                    sweep_next = '0;
                    if (bslot_reg == slot_reg)
                    begin
                        selfclr_next = 1'b1;
                    end
                    state_next = ST_RCLR;
                end
                else
                begin
                    ov_next    = 1'b1;
                    ordy_next  = ordy_reg && !selfclr_reg;
                    obase_next = base_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_RCLR:
            begin
                // Walk every row of the retiring slot.
                p_we       = 1'b1;
                p_waddr    = {bslot_reg, sweep_reg[RW-1:0]};
                t_we       = (sweep_reg[RW-1:0] == '0);
                t_waddr    = bslot_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[RW-1:0] == {RW{1'b1}})
                begin
                    base_next  = base_reg + 32'd1;
                    bslot_next = ((bslot_reg == LAST_SLOT) || (base_reg == 32'hFFFF_FFFF)) ?
                                 '0 : bslot_reg + 1'b1;
                    nret_next  = nret_reg + 1'b1;
                    state_next = ST_RCHK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            base_reg    <= '0;
            bslot_reg   <= '0;
            sweep_reg   <= '0;
            nret_reg    <= '0;
            selfclr_reg <= 1'b0;
            ov_reg      <= 1'b0;
            oin_reg     <= 1'b0;
            ocnt_reg    <= '0;
            ordy_reg    <= 1'b0;
            odone_reg   <= 1'b0;
            obase_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            bslot_reg   <= bslot_next;
            sweep_reg   <= (accept) ? {{SW{1'b0}}, sym_eff[fwps_pkg::SYMA_W-1:0], kind}
                                    : sweep_next;
            nret_reg    <= nret_next;
            selfclr_reg <= selfclr_next;
            ov_reg      <= ov_next;
            oin_reg     <= oin_next;
            ocnt_reg    <= ocnt_next;
            ordy_reg    <= ordy_next;
            odone_reg   <= odone_next;
            obase_reg   <= obase_next;
        end
    end

    // Word fields held for the execute stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            kind_reg  <= kind;
            sym0_reg  <= (sym_eff == 5'd0);
            valid_reg <= row_ok;
            inc_reg   <= inc_in;
            slot_reg  <= slot_in;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = ov_reg;
    assign in_window    = oin_reg;
    assign count        = ocnt_reg;
    assign encode_ready = ordy_reg;
    assign frame_done   = odone_reg;
    assign window_base  = obase_reg;

endmodule

[rtl/fwps_checker.sv]
// Port-level checker of the scoreboard and the bind that attaches it.
module fwps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic        in_window,
    input logic [15:0] count,
    input logic        encode_ready,
    input logic        frame_done,
    input logic [31:0] window_base
);

    // A rejected word reports nothing but the base.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_window |-> (count == 16'd0) && !encode_ready && !frame_done)
        else $error("rejected word carries nonzero fields");

    // The reported base only moves together with a result.
    a_base_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> $stable(window_base) || result_valid)
        else $error("window base changed without a result");

    // Every result follows an accepted word or work in progress.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) || $past(start))
        else $error("result without an accepted word");

endmodule

bind frame_window_progress_scoreboard fwps_checker u_fwps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .in_window    (in_window),
    .count        (count),
    .encode_ready (encode_ready),
    .frame_done   (frame_done),
    .window_base  (window_base)
);

[dv/tb_top.sv]
// Self-checking testbench for the frame window progress scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fwps_pkg::*;

    localparam int NKINDS = 12;
    localparam int ROWS_PER_SLOT = MAX_SYMBOLS * NKINDS;

    typedef struct packed {
        logic        in_window;
        logic [15:0] count;
        logic        encode_ready;
        logic        frame_done;
        logic [31:0] window_base;
    } progress_word_t;

    // Holds the predicted block state and the queue of results still owed.
    class progress_tracker;
        logic [15:0] counters [FRAME_WINDOW * ROWS_PER_SLOT];
        logic [15:0] task_tally [FRAME_WINDOW];
        logic        ready_bit [FRAME_WINDOW];
        logic [31:0] base;
        cfg_t        cfg;
        progress_word_t owed [$];
        int          mismatches;
        int          checked;

        function void clear_all();
            foreach (counters[i]) counters[i] = '0;
            foreach (task_tally[i]) task_tally[i] = '0;
            foreach (ready_bit[i]) ready_bit[i] = 1'b0;
            base = '0;
            cfg = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_TIME_SAMPLES: cfg.time_samples_per_symbol = val;
                REG_TASKS:        cfg.tasks_per_frame = val;
                REG_USERS:        cfg.users_count = val[11:0];
                REG_ZF_START:     cfg.zf_range_start = val[11:0];
                REG_ZF_END:       cfg.zf_range_end = val[11:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] sat_sum(logic [15:0] a, int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > 65535) ? 16'hFFFF : s[15:0];
        endfunction

        // Note an accepted word and push what the block must answer.
        function void note_word(logic [1:0] o, logic [3:0] k, logic [31:0] fr,
                                logic [4:0] sy, logic [11:0] amt, logic [11:0] sc);
            progress_word_t r;
            int unsigned slot, idx, inc, lo, hi, sym;
            r = '0;
            r.window_base = base;
            if (fr >= base && {32'd0, fr} < {32'd0, base} + FRAME_WINDOW) begin
                slot = fr % FRAME_WINDOW;
                if (o == OP_TASK) begin
                    task_tally[slot] = sat_sum(task_tally[slot], 1);
                    r.count = task_tally[slot];
                    r.frame_done = (task_tally[slot] == cfg.tasks_per_frame);
                    if (r.frame_done) begin
                        // Retire complete frames in order, at most one window's worth.
                        for (int n = 0; n < FRAME_WINDOW; n++) begin
                            int unsigned bs;
                            bs = base % FRAME_WINDOW;
                            if (task_tally[bs] != cfg.tasks_per_frame) break;
                            for (int j = 0; j < ROWS_PER_SLOT; j++)
                                counters[bs * ROWS_PER_SLOT + j] = '0;
                            task_tally[bs] = '0;
                            ready_bit[bs] = 1'b0;
                            base = base + 1;
                        end
                    end
                end else begin
                    sym = (k == KIND_PILOT || k == KIND_ZF) ? 0 : sy;
                    if (k < NKINDS && sym < MAX_SYMBOLS) begin
                        idx = slot * ROWS_PER_SLOT + sym * NKINDS + k;
                        if (o == OP_ADD) begin
                            inc = amt;
                            if (k == KIND_ZF) begin
                                lo = (sc > cfg.zf_range_start) ? sc : cfg.zf_range_start;
                                hi = sc + cfg.users_count;
                                if (hi > cfg.zf_range_end) hi = cfg.zf_range_end;
                                inc = (hi > lo) ? hi - lo : 0;
                            end
                            counters[idx] = sat_sum(counters[idx], inc);
                            if (k == KIND_TIME && sym == 0 &&
                                counters[idx] == cfg.time_samples_per_symbol)
                                ready_bit[slot] = 1'b1;
                        end
                        r.count = counters[idx];
                    end
                    r.frame_done = (task_tally[slot] == cfg.tasks_per_frame);
                end
                r.in_window = 1'b1;
                r.encode_ready = ready_bit[slot];
                r.window_base = base;
            end
            owed.push_back(r);
        endfunction

        function void check_word(progress_word_t got);
            progress_word_t exp;
            if (owed.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $realtime, got);
                mismatches++;
                return;
            end
            exp = owed.pop_front();
            checked++;
            if (got.in_window !== exp.in_window) begin
                $display("%0t: in_window exp %0d got %0d", $realtime, exp.in_window,
                         got.in_window);
                mismatches++;
            end
            if (got.count !== exp.count) begin
                $display("%0t: count exp %0d got %0d", $realtime, exp.count, got.count);
                mismatches++;
            end
            if (got.encode_ready !== exp.encode_ready) begin
                $display("%0t: encode_ready exp %0d got %0d", $realtime,
                         exp.encode_ready, got.encode_ready);
                mismatches++;
            end
            if (got.frame_done !== exp.frame_done) begin
                $display("%0t: frame_done exp %0d got %0d", $realtime, exp.frame_done,
                         got.frame_done);
                mismatches++;
            end
            if (got.window_base !== exp.window_base) begin
                $display("%0t: window_base exp %0h got %0h", $realtime,
                         exp.window_base, got.window_base);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [3:0]  kind;
    logic [31:0] frame_number;
    logic [4:0]  symbol_index;
    logic [11:0] amount;
    logic [11:0] sc_index;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        result_valid;
    logic        in_window;
    logic [15:0] count;
    logic        encode_ready;
    logic        frame_done;
    logic [31:0] window_base;

    frame_window_progress_scoreboard dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .kind(kind),
        .frame_number(frame_number), .symbol_index(symbol_index), .amount(amount),
        .sc_index(sc_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .result_valid(result_valid), .in_window(in_window),
        .count(count), .encode_ready(encode_ready), .frame_done(frame_done),
        .window_base(window_base)
    );

    progress_tracker tracker;
    int gap_pct;        // chance in percent that the sender skips a cycle
    int words_sent;
    int retire_events;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Every strobed result is taken at the rising edge that ends its cycle.
    always @(posedge clk) begin
        if (rst_n && result_valid)
            tracker.check_word({in_window, count, encode_ready, frame_done, window_base});
    end

    // Registers are written while no word is in flight, so the model sees them at once.
    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Present one word and hold it until the block takes it. Idle gaps are inserted
    // before the word; start stays high across back-to-back words.
    task automatic send_word(logic [1:0] o, logic [3:0] k, logic [31:0] fr,
                             logic [4:0] sy, logic [11:0] amt, logic [11:0] sc);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        op = o;
        kind = k;
        frame_number = fr;
        symbol_index = sy;
        amount = amt;
        sc_index = sc;
        do @(posedge clk); while (busy);
        tracker.note_word(o, k, fr, sy, amt, sc);
        if (o == OP_TASK) retire_events++;
        words_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // Wait until every owed result has arrived, then let a retirement sweep finish.
    task automatic drain();
        start = 1'b0;
        while (tracker.owed.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    // Random word: mostly in-window traffic, some out-of-window and odd fields.
    task automatic random_word();
        logic [1:0]  o;
        logic [3:0]  k;
        logic [31:0] fr;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45) o = OP_ADD;
        else if (sel < 65) o = OP_READ;
        else if (sel < 95) o = OP_TASK;
        else o = 2'd3;
        k = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NKINDS - 1));
        sel = $urandom_range(99);
        if (sel < 85) fr = tracker.base + $urandom_range(FRAME_WINDOW - 1);
        else if (sel < 93) fr = tracker.base + FRAME_WINDOW + $urandom_range(3);
        else if (sel < 97) fr = tracker.base - 1 - $urandom_range(3);
        else fr = $urandom;
        send_word(o, k, fr, 5'($urandom), ($urandom_range(3) == 0) ? 12'($urandom) :
                  12'($urandom_range(40)), 12'($urandom));
    endtask

    // Random register setting; small task targets keep frames retiring.
    task automatic random_cfg(bit extreme);
        write_cfg(REG_TIME_SAMPLES, extreme ? 16'hFFFF : 16'($urandom_range(60)));
        write_cfg(REG_TASKS, extreme ? 16'($urandom_range(1) ? 0 : 16'hFFFF) :
                  16'($urandom_range(1, 4)));
        write_cfg(REG_USERS, extreme ? 16'h0FFF : 16'($urandom_range(64)));
        write_cfg(REG_ZF_START, extreme ? 16'h0000 : 16'($urandom_range(200)));
        write_cfg(REG_ZF_END, extreme ? 16'h0FFF : 16'($urandom_range(100, 4095)));
    endtask

    initial begin
        tracker = new();
        tracker.clear_all();
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_READ;
        kind = '0;
        frame_number = '0;
        symbol_index = '0;
        amount = '0;
        sc_index = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        gap_pct = 0;
        words_sent = 0;
        retire_events = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: edges of the fields and each special case.
        write_cfg(REG_TIME_SAMPLES, 16'd10);
        write_cfg(REG_TASKS, 16'd2);
        write_cfg(REG_USERS, 16'd100);
        write_cfg(REG_ZF_START, 16'd50);
        write_cfg(REG_ZF_END, 16'd120);
        send_word(OP_ADD, KIND_TIME, 32'd0, 5'd0, 12'd4, 12'd0);
        send_word(OP_ADD, KIND_TIME, 32'd0, 5'd0, 12'd6, 12'd0);      // hits target
        send_word(OP_ADD, KIND_TIME, 32'd0, 5'd0, 12'd1, 12'd0);      // passes it
        send_word(OP_ADD, KIND_ZF, 32'd1, 5'd31, 12'd0, 12'd30);      // partial overlap
        send_word(OP_ADD, KIND_ZF, 32'd1, 5'd0, 12'd0, 12'd4095);     // no overlap
        send_word(OP_ADD, KIND_PILOT, 32'd2, 5'd17, 12'hFFF, 12'd0);  // symbol ignored
        send_word(OP_READ, KIND_PILOT, 32'd2, 5'd0, 12'd0, 12'd0);
        send_word(OP_ADD, 4'd12, 32'd3, 5'd0, 12'd5, 12'd0);          // kind too large
        send_word(OP_READ, 4'd15, 32'd3, 5'd0, 12'd0, 12'd0);
        send_word(2'd3, 4'd11, 32'd0, 5'd31, 12'd0, 12'd0);           // unused op reads
        send_word(OP_ADD, 4'd5, 32'd8, 5'd0, 12'd1, 12'd0);           // past the window
        send_word(OP_READ, 4'd0, 32'hFFFF_FFFF, 5'd0, 12'd0, 12'd0);
        for (int i = 0; i < 17; i++)                                  // saturate
            send_word(OP_ADD, 4'd7, 32'd4, 5'd3, 12'hFFF, 12'd0);
        send_word(OP_TASK, 4'd0, 32'd1, 5'd0, 12'd0, 12'd0);
        send_word(OP_TASK, 4'd0, 32'd1, 5'd0, 12'd0, 12'd0);          // done, no retire
        send_word(OP_TASK, 4'd0, 32'd0, 5'd0, 12'd0, 12'd0);
        send_word(OP_TASK, 4'd0, 32'd0, 5'd0, 12'd0, 12'd0);          // retires 0 and 1
        send_word(OP_TASK, 4'd0, 32'd3, 5'd0, 12'd0, 12'd0);
        send_word(OP_TASK, 4'd0, 32'd3, 5'd0, 12'd0, 12'd0);
        send_word(OP_TASK, 4'd0, 32'd3, 5'd0, 12'd0, 12'd0);          // past target
        drain();

        // A zero task target is never matched by a count, so nothing retires.
        write_cfg(REG_TASKS, 16'd0);
        send_word(OP_TASK, 4'd0, tracker.base, 5'd0, 12'd0, 12'd0);
        drain();

        // Random part in three phases of sender idling, with setting changes.
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 32 : ((ph == 1) ? 70 : 0);
            for (int b = 0; b < 6; b++) begin
                random_cfg(b == 5);
                for (int i = 0; i < 95; i++) random_word();
                drain();   // the sender holds off until all owed results are in
            end
        end

        drain();
        repeat (20) @(negedge clk);
        $display("Run covered %0d words (%0d task reports), %0d results checked, base %0h.",
                 words_sent, retire_events, tracker.checked, tracker.base);
        if (tracker.mismatches == 0 && tracker.owed.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
